>>> rtl/tpmlf_pkg.sv
// ----------------------------------------------------------------------------
// tpmlf_pkg: shared types and constants
// Field widths, port codes and the control bundle that drives a table chain.
// ----------------------------------------------------------------------------
`default_nettype none

package tpmlf_pkg;

    // Field widths
    localparam int PORT_W  = 2;
    localparam int MAC_W   = 48;
    localparam int COUNT_W = 7;

    // Default table size
    localparam int DEFAULT_TABLE_DEPTH = 64;

    // Ingress port codes
    localparam logic [PORT_W-1:0] PORT_LEFT  = 2'd0;
    localparam logic [PORT_W-1:0] PORT_RIGHT = 2'd1;

    // Egress port codes
    localparam logic EGRESS_LEFT  = 1'b0;
    localparam logic EGRESS_RIGHT = 1'b1;

    // Control bundle from the sequencer to one table chain
    typedef struct packed {
        logic hit_clr;  // new lookup starts, drop the old hit
        logic scan;     // rotate the ring one place and compare at the head
        logic learn;    // store the key at the first free cell
    } chain_ctrl_t;

    // Status bundle from one table chain
    typedef struct packed {
        logic hit;      // key matched a stored entry during the last scan
        logic full;     // every cell holds an entry
    } chain_stat_t;

endpackage

`default_nettype wire

>>> rtl/tpmlf_if.sv
// ----------------------------------------------------------------------------
// tpmlf_if: channel interfaces
// Header channel into the filter and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpmlf_hdr_if;
    logic                         valid;
    logic                         ready;
    logic [tpmlf_pkg::PORT_W-1:0] ingress_port;
    logic [tpmlf_pkg::MAC_W-1:0]  source_mac;

    modport source (output valid, output ingress_port, output source_mac, input ready);
    modport sink   (input valid, input ingress_port, input source_mac, output ready);
endinterface

interface tpmlf_res_if;
    logic                          valid;
    logic                          ready;
    logic                          forward;
    logic                          egress_port;
    logic                          learned_new;
    logic                          table_full;
    logic [tpmlf_pkg::COUNT_W-1:0] left_count;
    logic [tpmlf_pkg::COUNT_W-1:0] right_count;

    modport source (output valid, output forward, output egress_port, output learned_new,
                    output table_full, output left_count, output right_count, input ready);
    modport sink   (input valid, input forward, input egress_port, input learned_new,
                    input table_full, input left_count, input right_count, output ready);
endinterface

`default_nettype wire

>>> rtl/two_port_mac_learning_filter.sv
// ----------------------------------------------------------------------------
// two_port_mac_learning_filter: two-port learning bridge source filter
// Forwards a left or right frame to the opposite port unless its source is learned there,
// and learns forwarded sources into the ingress side's table.
// ----------------------------------------------------------------------------
//
//  channel  role   handshake      payload
//  hdr      sink   valid/ready    ingress_port, source_mac
//  res      source valid/ready    forward, egress_port, learned_new, table_full,
//                                 left_count, right_count
//
// A left or right header goes from its accept state through a scan (one full
// rotation of both cell rings past their head comparators) to a decision state;
// a header from another port goes from its accept state straight to the decision
// state. A new header is taken only after the last one's decision.
// The result is valid from the cycle after the decision. One item is in work
// at a time. Reset clears both fill counts and the control state; table cells
// need none.
// A result waits in the output register; the next header is taken meanwhile,
// and its decision cycle waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module two_port_mac_learning_filter
#(
    parameter int TABLE_DEPTH = tpmlf_pkg::DEFAULT_TABLE_DEPTH
)
(
    input wire logic clk,
    input wire logic rst_n,
    tpmlf_hdr_if.sink   hdr,
    tpmlf_res_if.source res
);
    import tpmlf_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [PORT_W-1:0] port_reg;
    logic [MAC_W-1:0]  mac_reg;

    logic             hdr_take;
    logic             res_free;
    logic             decide;

    chain_ctrl_t      left_ctrl;
    chain_ctrl_t      right_ctrl;
    chain_stat_t      left_stat;
    chain_stat_t      right_stat;
    logic [CNT_W-1:0] left_cnt;
    logic [CNT_W-1:0] right_cnt;

    logic             is_side;
    logic             from_right;
    logic             far_hit;
    logic             own_hit;
    logic             own_full;
    logic             fwd;
    logic             need_learn;
    logic             learn;

    logic             valid_reg;
    logic             forward_reg;
    logic             egress_reg;
    logic             learned_reg;
    logic             full_reg;
    logic [COUNT_W-1:0] left_count_reg;
    logic [COUNT_W-1:0] right_count_reg;

    assign hdr.ready = (state_reg == ST_IDLE);
    assign hdr_take  = hdr.valid && hdr.ready;
    assign res_free  = !valid_reg || res.ready;
    assign decide    = (state_reg == ST_DECIDE) && res_free;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (hdr_take)
                begin
                    state_next = hdr.ingress_port[1] ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Header capture
    always_ff @(posedge clk)
    begin
        if (hdr_take)
        begin
            port_reg <= hdr.ingress_port;
            mac_reg  <= hdr.source_mac;
        end
    end

    // Forward and learn decision
    assign is_side    = !port_reg[1];
    assign from_right = (port_reg == PORT_RIGHT);
    assign far_hit    = from_right ? left_stat.hit : right_stat.hit;
    assign own_hit    = from_right ? right_stat.hit : left_stat.hit;
    assign own_full   = from_right ? right_stat.full : left_stat.full;
    assign fwd        = is_side && !far_hit;
    assign need_learn = fwd && !own_hit;
    assign learn      = need_learn && !own_full;

    // Chain control
    always_comb
    begin
        left_ctrl.hit_clr  = hdr_take;
        left_ctrl.scan     = (state_reg == ST_SCAN);
        left_ctrl.learn    = decide && learn && !from_right;
        right_ctrl.hit_clr = hdr_take;
        right_ctrl.scan    = (state_reg == ST_SCAN);
        right_ctrl.learn   = decide && learn && from_right;
    end

    tpmlf_chain
    #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    )
    u_left
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (left_ctrl),
        .scan_idx (idx_reg),
        .key      (mac_reg),
        .stat     (left_stat),
        .count    (left_cnt)
    );

    tpmlf_chain
    #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    )
    u_right
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (right_ctrl),
        .scan_idx (idx_reg),
        .key      (mac_reg),
        .stat     (right_stat),
        .count    (right_cnt)
    );

    // Output register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (decide)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output register: payload, counts as they stand after this item
    always_ff @(posedge clk)
    begin
        if (decide)
        begin
            forward_reg     <= fwd;
            egress_reg      <= (fwd && !from_right) ? EGRESS_RIGHT : EGRESS_LEFT;
            learned_reg     <= learn;
            full_reg        <= need_learn && own_full;
            left_count_reg  <= COUNT_W'(left_cnt + CNT_W'(left_ctrl.learn));
            right_count_reg <= COUNT_W'(right_cnt + CNT_W'(right_ctrl.learn));
        end
    end

    assign res.valid       = valid_reg;
    assign res.forward     = forward_reg;
    assign res.egress_port = egress_reg;
    assign res.learned_new = learned_reg;
    assign res.table_full  = full_reg;
    assign res.left_count  = left_count_reg;
    assign res.right_count = right_count_reg;

endmodule

`default_nettype wire

>>> rtl/tpmlf_cell.sv
// ----------------------------------------------------------------------------
// tpmlf_cell: one table entry
// Holds one address; takes its neighbor's entry on a rotate, or the key on a write.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmlf_cell
(
    input  wire logic                        clk,
    input  wire logic                        shift,
    input  wire logic                        load,
    input  wire logic [tpmlf_pkg::MAC_W-1:0] neighbor_mac,
    input  wire logic [tpmlf_pkg::MAC_W-1:0] load_mac,
    output      logic [tpmlf_pkg::MAC_W-1:0] entry
);
    import tpmlf_pkg::*;

    logic [MAC_W-1:0] entry_reg;

    // Entry storage, no reset: read only once written
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= load_mac;
        end
        else if (shift)
        begin
            entry_reg <= neighbor_mac;
        end
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

>>> rtl/tpmlf_chain.sv
// ----------------------------------------------------------------------------
// tpmlf_chain: one learned-address table as a ring of cells
// Entries rotate one place per scan cycle past a single comparator at the head;
// after DEPTH rotations every entry is back at its own cell.
// ----------------------------------------------------------------------------
`default_nettype none

module tpmlf_chain
#(
    parameter int DEPTH = tpmlf_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire tpmlf_pkg::chain_ctrl_t      ctrl,
    input  wire logic [IDX_W-1:0]            scan_idx,
    input  wire logic [tpmlf_pkg::MAC_W-1:0] key,
    output      tpmlf_pkg::chain_stat_t      stat,
    output      logic [CNT_W-1:0]            count
);
    import tpmlf_pkg::*;

    logic [MAC_W-1:0] entry [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             hit_reg;
    logic             hit_next;
    logic             head_match;

    // Ring of cells: cell i takes cell i+1, the last takes the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        tpmlf_cell u_cell
        (
            .clk          (clk),
            .shift        (ctrl.scan),
            .load         (ctrl.learn && (count_reg == CNT_W'(i))),
            .neighbor_mac (entry[(i + 1) % DEPTH]),
            .load_mac     (key),
            .entry        (entry[i])
        );
    end

    // Head compare, only for entries below the fill count
    assign head_match = (entry[0] == key) && ({1'b0, CNT_W'(scan_idx)} < {1'b0, count_reg});

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.hit_clr)
        begin
            hit_next = 1'b0;
        end
        else if (ctrl.scan && head_match)
        begin
            hit_next = 1'b1;
        end
    end

    assign count_next = ctrl.learn ? count_reg + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            hit_reg   <= hit_next;
        end
    end

    assign stat.hit  = hit_reg;
    assign stat.full = (count_reg == CNT_W'(DEPTH));
    assign count     = count_reg;

endmodule

`default_nettype wire
